>>> hdl/stq_pkg.sv
// stq_pkg: types, constants and helpers for the sorted timer queue
// used by every module of the block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int TIME_W   = 48;
    localparam int IVAL_W   = 32;
    localparam int ID_W     = 16;
    localparam int MIN_W    = 20;

    localparam logic [MIN_W-1:0] MIN_DELAY_RESET = MIN_W'(100);

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [1:0] KIND_ADD_ACK   = 2'd0;
    localparam logic [1:0] KIND_FIRED     = 2'd1;
    localparam logic [1:0] KIND_TICK_DONE = 2'd2;

    typedef struct packed {
        logic              command;
        logic [ID_W-1:0]   timer_id;
        logic [TIME_W-1:0] expiration;
        logic [IVAL_W-1:0] interval_us;
        logic [TIME_W-1:0] now_us;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ID_W-1:0]   fired_id;
        logic              is_earliest;
        logic              arm_valid;
        logic [TIME_W-1:0] arm_delay;
        logic              queue_empty;
        logic              overflow;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic [TIME_W-1:0] exp;
        logic [IVAL_W-1:0] ival;
        logic [ID_W-1:0]   id;
    } t_entry;

    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
    } t_mem_req;

    typedef enum logic {
        ALU_SUB,
        ALU_ADD_SAT
    } t_alu_op;

    typedef struct packed {
        t_alu_op           op;
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [TIME_W-1:0] res;
        logic              borrow;
    } t_alu_rsp;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_emit;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_START,
        S_INS_SCAN,
        S_INS_PUT,
        S_TK_START,
        S_TK_CHK,
        S_TK_POP,
        S_TK_RE,
        S_TK_RE_D,
        S_TK_ARM,
        S_ARM_SUB,
        S_ARM_MIN,
        S_FINAL
    } t_state;

    // circular slot of queue position off counted from head
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] off);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(head) + (CNT_W+1)'(off);
        if (s >= (CNT_W+1)'(CAPACITY)) begin
            s = s - (CNT_W+1)'(CAPACITY);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hdl/stq_alu.sv
// stq_alu: shared 48-bit add / subtract unit with saturation and borrow
// depends on stq_pkg
`timescale 1ns / 1ps
`default_nettype none

module stq_alu import stq_pkg::*; (
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic              sub;
    logic [TIME_W-1:0] b_in;
    logic [TIME_W:0]   sum;

    assign sub  = (i_req.op == ALU_SUB);
    assign b_in = sub ? ~i_req.b : i_req.b;
    assign sum  = {1'b0, i_req.a} + {1'b0, b_in} + (TIME_W+1)'(sub);

    always_comb begin
        o_rsp.borrow = sub & ~sum[TIME_W];
        if (!sub && sum[TIME_W]) begin
            o_rsp.res = {TIME_W{1'b1}};
        end else begin
            o_rsp.res = sum[TIME_W-1:0];
        end
    end

endmodule

`default_nettype wire

>>> hdl/stq_store.sv
// stq_store: timer entry memory, one write and one registered read per cycle
// depends on stq_pkg
`timescale 1ns / 1ps
`default_nettype none

module stq_store import stq_pkg::*; (
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rdata
);

    t_entry r_mem [CAPACITY];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/stq_ctrl.sv
// stq_ctrl: sequencer for sorted insert, expiry scan, reinsertion and arm delay
// depends on stq_pkg; drives stq_store and stq_alu
`timescale 1ns / 1ps
`default_nettype none

module stq_ctrl import stq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  t_in_item         i_item,
    output logic             o_in_ready,
    input  logic             i_cfg_we,
    input  logic [MIN_W-1:0] i_cfg_data,
    input  logic             i_out_free,
    output t_emit            o_emit,
    output t_mem_req         o_mem,
    input  t_entry           i_rdata,
    output t_alu_req         o_alu,
    input  t_alu_rsp         i_alu
);

    t_state            r_state, n_state;
    logic              r_cmd, n_cmd;
    t_entry            r_x, n_x;
    logic [TIME_W-1:0] r_now, n_now;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_nf, n_nf;
    logic [CNT_W-1:0]  r_i, n_i;
    logic [IDX_W-1:0]  r_j, n_j;
    logic              r_early, n_early;
    logic              r_ovf, n_ovf;
    logic [TIME_W-1:0] r_delay, n_delay;
    logic [MIN_W-1:0]  r_min, n_min;

    logic             more_to_scan;
    logic             queue_full;
    logic [CNT_W-1:0] j_next;
    t_state           ins_exit_early, ins_exit_late;

    assign j_next       = CNT_W'(r_j) + CNT_W'(1);
    assign more_to_scan = (j_next < r_count);
    assign queue_full   = (r_count == CNT_W'(CAPACITY));
    assign ins_exit_early = (r_cmd == CMD_TICK) ? S_TK_RE : S_ARM_SUB;
    assign ins_exit_late  = (r_cmd == CMD_TICK) ? S_TK_RE : S_FINAL;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_item.command == CMD_TICK) begin
                        n_state = S_TK_START;
                    end else if (queue_full) begin
                        n_state = S_FINAL;
                    end else begin
                        n_state = S_INS_START;
                    end
                end
            end
            S_INS_START: n_state = (r_count == '0) ? ins_exit_early : S_INS_SCAN;
            S_INS_SCAN: begin
                if (i_alu.borrow) begin
                    n_state = (r_j == '0) ? S_INS_PUT : S_INS_SCAN;
                end else begin
                    n_state = ins_exit_late;
                end
            end
            S_INS_PUT:  n_state = ins_exit_early;
            S_TK_START: n_state = (r_count == '0) ? S_TK_ARM : S_TK_CHK;
            S_TK_CHK: begin
                if (!i_alu.borrow) begin
                    n_state = S_TK_POP;
                end else if (i_out_free && !more_to_scan) begin
                    n_state = S_TK_POP;
                end
            end
            S_TK_POP:  n_state = S_TK_RE;
            S_TK_RE:   n_state = (r_i == r_nf) ? S_TK_ARM : S_TK_RE_D;
            S_TK_RE_D: n_state = (i_rdata.ival == '0) ? S_TK_RE : S_INS_START;
            S_TK_ARM:  n_state = (r_count == '0) ? S_FINAL : S_ARM_SUB;
            S_ARM_SUB: n_state = S_ARM_MIN;
            S_ARM_MIN: n_state = S_FINAL;
            S_FINAL:   n_state = i_out_free ? S_IDLE : S_FINAL;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_cmd   = r_cmd;
        n_x     = r_x;
        n_now   = r_now;
        n_head  = r_head;
        n_count = r_count;
        n_nf    = r_nf;
        n_i     = r_i;
        n_j     = r_j;
        n_early = r_early;
        n_ovf   = r_ovf;
        n_delay = r_delay;
        n_min   = i_cfg_we ? i_cfg_data : r_min;

        o_in_ready = (r_state == S_IDLE);
        o_mem      = '0;
        o_alu.op   = ALU_SUB;
        o_alu.a    = '0;
        o_alu.b    = '0;
        o_emit     = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd    = i_item.command;
                    n_x.exp  = i_item.expiration;
                    n_x.ival = i_item.interval_us;
                    n_x.id   = i_item.timer_id;
                    n_now    = i_item.now_us;
                    n_nf     = '0;
                    n_early  = 1'b0;
                    n_ovf    = (i_item.command == CMD_ADD) && queue_full;
                end
            end
            S_INS_START: begin
                if (r_count == '0) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_head;
                    o_mem.wdata = r_x;
                    n_count     = r_count + CNT_W'(1);
                    n_early     = 1'b1;
                    if (r_cmd == CMD_TICK) begin
                        n_i = r_i + CNT_W'(1);
                    end
                end else begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = slot_of(r_head, r_count - CNT_W'(1));
                    n_j         = IDX_W'(r_count - CNT_W'(1));
                end
            end
            S_INS_SCAN: begin
                o_alu.a     = r_x.exp;
                o_alu.b     = i_rdata.exp;
                o_mem.we    = 1'b1;
                o_mem.waddr = slot_of(r_head, j_next);
                if (i_alu.borrow) begin
                    o_mem.wdata = i_rdata;
                    if (r_j != '0) begin
                        o_mem.re    = 1'b1;
                        o_mem.raddr = slot_of(r_head, CNT_W'(r_j) - CNT_W'(1));
                        n_j         = r_j - IDX_W'(1);
                    end
                end else begin
                    o_mem.wdata = r_x;
                    n_count     = r_count + CNT_W'(1);
                    n_early     = 1'b0;
                    if (r_cmd == CMD_TICK) begin
                        n_i = r_i + CNT_W'(1);
                    end
                end
            end
            S_INS_PUT: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_head;
                o_mem.wdata = r_x;
                n_count     = r_count + CNT_W'(1);
                n_early     = 1'b1;
                if (r_cmd == CMD_TICK) begin
                    n_i = r_i + CNT_W'(1);
                end
            end
            S_TK_START: begin
                if (r_count != '0) begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_head;
                    n_j         = '0;
                end
            end
            S_TK_CHK: begin
                o_alu.a = i_rdata.exp;
                o_alu.b = r_now;
                if (i_alu.borrow) begin
                    o_emit.valid         = 1'b1;
                    o_emit.item.kind     = KIND_FIRED;
                    o_emit.item.fired_id = i_rdata.id;
                    if (i_out_free) begin
                        n_nf = r_nf + CNT_W'(1);
                        if (more_to_scan) begin
                            o_mem.re    = 1'b1;
                            o_mem.raddr = slot_of(r_head, j_next);
                            n_j         = r_j + IDX_W'(1);
                        end
                    end
                end
            end
            S_TK_POP: begin
                n_head  = slot_of(r_head, r_nf);
                n_count = r_count - r_nf;
                n_i     = '0;
            end
            S_TK_RE: begin
                if (r_i != r_nf) begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = slot_of(r_head, CNT_W'(CAPACITY) - r_nf + r_i);
                end
            end
            S_TK_RE_D: begin
                o_alu.op = ALU_ADD_SAT;
                o_alu.a  = r_now;
                o_alu.b  = TIME_W'(i_rdata.ival);
                if (i_rdata.ival == '0) begin
                    n_i = r_i + CNT_W'(1);
                end else begin
                    n_x.exp  = i_alu.res;
                    n_x.ival = i_rdata.ival;
                    n_x.id   = i_rdata.id;
                end
            end
            S_TK_ARM: begin
                if (r_count != '0) begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_head;
                end
            end
            S_ARM_SUB: begin
                o_alu.a = (r_cmd == CMD_TICK) ? i_rdata.exp : r_x.exp;
                o_alu.b = r_now;
                n_delay = i_alu.borrow ? '0 : i_alu.res;
            end
            S_ARM_MIN: begin
                o_alu.a = r_delay;
                o_alu.b = TIME_W'(r_min);
                if (i_alu.borrow) begin
                    n_delay = TIME_W'(r_min);
                end
            end
            S_FINAL: begin
                o_emit.valid = 1'b1;
                o_emit.item.last = 1'b1;
                if (r_cmd == CMD_TICK) begin
                    o_emit.item.kind        = KIND_TICK_DONE;
                    o_emit.item.arm_valid   = (r_count != '0);
                    o_emit.item.arm_delay   = (r_count != '0) ? r_delay : '0;
                    o_emit.item.queue_empty = (r_count == '0);
                end else begin
                    o_emit.item.kind        = KIND_ADD_ACK;
                    o_emit.item.is_earliest = r_early;
                    o_emit.item.arm_valid   = r_early;
                    o_emit.item.arm_delay   = r_early ? r_delay : '0;
                    o_emit.item.overflow    = r_ovf;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_min   <= MIN_DELAY_RESET;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_min   <= n_min;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_x     <= n_x;
        r_now   <= n_now;
        r_nf    <= n_nf;
        r_i     <= n_i;
        r_j     <= n_j;
        r_early <= n_early;
        r_ovf   <= n_ovf;
        r_delay <= n_delay;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("timer count above capacity");

    a_write_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.we |-> !queue_full)
        else $error("entry write while queue full");

    a_emit_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit.valid |-> (r_state == S_TK_CHK || r_state == S_FINAL))
        else $error("item emitted outside scan or final state");

    a_scan_tracks_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TK_CHK) |-> (r_nf == CNT_W'(r_j)))
        else $error("fired count out of step with scan index");

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state != S_IDLE))
        else $error("accepted item did not start work");

endmodule

`default_nettype wire

>>> hdl/sorted_timer_queue.sv
// sorted_timer_queue: top level of the sorted timer queue with result register
// depends on stq_pkg, stq_alu, stq_store, stq_ctrl
//
//   channel   dir   handshake                 payload
//   in        in    i_in_valid / o_in_ready   i_in_item  (t_in_item)
//   out       out   o_out_valid / i_out_ready o_out_item (t_out_item)
//   cfg       in    i_cfg_we                  i_cfg_data (min_arm_delay)
//
// add: overflow ack if full; else written as head into an empty queue or placed by a
//   scan on the one read port, plus head put and arm delay when it becomes the head
// tick: on an empty queue only the done item, else expiry scan, pop, and the insert
//   scan of each repeating fired timer; every compare and add goes through the one alu
// reset clears state, count, head, min_arm_delay and the result valid flag only
// a stalled result stalls the sequencer; o_in_ready is high only when idle
`timescale 1ns / 1ps
`default_nettype none

module sorted_timer_queue import stq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item,
    input  logic             i_cfg_we,
    input  logic [MIN_W-1:0] i_cfg_data
);

    t_emit     emit;
    t_mem_req  mem_req;
    t_entry    rdata;
    t_alu_req  alu_req;
    t_alu_rsp  alu_rsp;
    logic      out_free;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out_item;

    stq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_item     (i_in_item),
        .o_in_ready (o_in_ready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_out_free (out_free),
        .o_emit     (emit),
        .o_mem      (mem_req),
        .i_rdata    (rdata),
        .o_alu      (alu_req),
        .i_alu      (alu_rsp)
    );

    stq_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    stq_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (emit.valid && out_free) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.valid && out_free) begin
            r_out_item <= emit.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire
